>>> rtl/rgb_block_average_downscaler_defines.svh
// ----------------------------------------------------------------------------
// rgb block average downscaler assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RGB_BLOCK_AVERAGE_DOWNSCALER_DEFINES_SVH
`define RGB_BLOCK_AVERAGE_DOWNSCALER_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define RBAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb downscaler check failed");

// next-cycle implication, ignored while in reset
`define RBAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb downscaler check failed");

`endif

>>> rtl/rbad_pkg.sv
// ----------------------------------------------------------------------------
// rbad_pkg
// types and constants of the rgb block average downscaler
// ----------------------------------------------------------------------------
package rbad_pkg;

  localparam int DEF_MAX_SOURCE_WIDTH = 2048;
  localparam int DEF_MAX_OUTPUT_WIDTH = 2048;
  localparam int DEF_MAX_BLOCK_SIZE   = 64;

  localparam int HEIGHT_LIMIT = 2048;
  localparam int CFG_W    = 12;  // widest register
  localparam int CIDX_W   = 3;
  localparam int SZ_W     = 14;  // holds any clamped size
  localparam int BK_W     = 9;   // holds any clamped block size
  localparam int PR_W     = SZ_W + BK_W;
  localparam int AREA_W   = 2 * BK_W;
  localparam int SUM_W    = 20;
  localparam int SR_W     = 11;  // source row
  localparam int OR_W     = 12;  // output row
  localparam int CNT_W    = 5;   // divider step count
  localparam int PIX_W    = 8;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_BLOCK_WIDTH   = 3'd2,
    CFG_BLOCK_HEIGHT  = 3'd3,
    CFG_OUTPUT_WIDTH  = 3'd4,
    CFG_OUTPUT_HEIGHT = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_W,
    ST_DIV_H,
    ST_UPDATE,
    ST_DIV_R,
    ST_DIV_G,
    ST_DIV_B,
    ST_OUT
  } state_t;

endpackage

>>> rtl/rgb_block_average_downscaler.sv
// ----------------------------------------------------------------------------
// rgb_block_average_downscaler
// box filter downscaler: averages each tile of the source frame into one pixel
// ----------------------------------------------------------------------------
// channel  | direction | contents
// s_*      | in        | source pixel, tdata = red, green, blue (low bits up)
// m_*      | out       | tile mean, tdata = red, green, blue; tlast = frame done
// cfg_*    | in        | register write, index and data
//
// each pixel passes twice through the shared 20 step divider (the
// effective output width and height are found per pixel); a pixel that ends
// a tile takes three more divisions, one per colour, before it is handed over
// rst is synchronous; the column sum memory is not cleared
// a stalled output holds in its register while the next pixel is taken in
// ----------------------------------------------------------------------------
module rgb_block_average_downscaler #(
  parameter int MAX_SOURCE_WIDTH = rbad_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_OUTPUT_WIDTH = rbad_pkg::DEF_MAX_OUTPUT_WIDTH,
  parameter int MAX_BLOCK_SIZE   = rbad_pkg::DEF_MAX_BLOCK_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // pixel_red, pixel_green, pixel_blue
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // mean_red, mean_green, mean_blue
  output logic                          m_tlast,   // frame_done
  input  logic                          cfg_we,
  input  logic [rbad_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [rbad_pkg::CFG_W-1:0]    cfg_data
);

  localparam int SZ_W   = rbad_pkg::SZ_W;
  localparam int BK_W   = rbad_pkg::BK_W;
  localparam int PR_W   = rbad_pkg::PR_W;
  localparam int SUM_W  = rbad_pkg::SUM_W;
  localparam int AREA_W = rbad_pkg::AREA_W;
  localparam int SC_W   = $clog2(MAX_SOURCE_WIDTH);
  localparam int PH_W   = $clog2(MAX_BLOCK_SIZE + 1);
  localparam int OC_W   = $clog2(MAX_OUTPUT_WIDTH + 1);
  localparam int OA_W   = $clog2(MAX_OUTPUT_WIDTH);
  localparam int SR_W   = rbad_pkg::SR_W;
  localparam int OR_W   = rbad_pkg::OR_W;
  localparam int PIX_W  = rbad_pkg::PIX_W;

  // configuration registers
  logic [11:0] source_width, source_height, output_width, output_height;
  logic [6:0]  block_width, block_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 12'd320;
      source_height <= 12'd240;
      block_width   <= 7'd1;
      block_height  <= 7'd1;
      output_width  <= 12'd320;
      output_height <= 12'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        rbad_pkg::CFG_SOURCE_WIDTH:  source_width  <= cfg_data;
        rbad_pkg::CFG_SOURCE_HEIGHT: source_height <= cfg_data;
        rbad_pkg::CFG_BLOCK_WIDTH:   block_width   <= cfg_data[6:0];
        rbad_pkg::CFG_BLOCK_HEIGHT:  block_height  <= cfg_data[6:0];
        rbad_pkg::CFG_OUTPUT_WIDTH:  output_width  <= cfg_data;
        rbad_pkg::CFG_OUTPUT_HEIGHT: output_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [SZ_W-1:0] sw, sh, ow_c, oh_c;
  logic [BK_W-1:0] bw, bh;

  always_comb begin
    sw   = (source_width == '0) ? SZ_W'(1) :
           (SZ_W'(source_width) > SZ_W'(MAX_SOURCE_WIDTH)) ? SZ_W'(MAX_SOURCE_WIDTH) :
           SZ_W'(source_width);
    sh   = (source_height == '0) ? SZ_W'(1) :
           (SZ_W'(source_height) > SZ_W'(rbad_pkg::HEIGHT_LIMIT)) ?
           SZ_W'(rbad_pkg::HEIGHT_LIMIT) : SZ_W'(source_height);
    ow_c = (output_width == '0) ? SZ_W'(1) :
           (SZ_W'(output_width) > SZ_W'(MAX_OUTPUT_WIDTH)) ? SZ_W'(MAX_OUTPUT_WIDTH) :
           SZ_W'(output_width);
    oh_c = (output_height == '0) ? SZ_W'(1) :
           (SZ_W'(output_height) > SZ_W'(rbad_pkg::HEIGHT_LIMIT)) ?
           SZ_W'(rbad_pkg::HEIGHT_LIMIT) : SZ_W'(output_height);
    bw   = (block_width == '0) ? BK_W'(1) :
           (BK_W'(block_width) > BK_W'(MAX_BLOCK_SIZE)) ? BK_W'(MAX_BLOCK_SIZE) :
           BK_W'(block_width);
    bh   = (block_height == '0) ? BK_W'(1) :
           (BK_W'(block_height) > BK_W'(MAX_BLOCK_SIZE)) ? BK_W'(MAX_BLOCK_SIZE) :
           BK_W'(block_height);
  end

  // position counters
  logic [SC_W-1:0] source_column, source_column_next;
  logic [SR_W-1:0] source_row, source_row_next;
  logic [PH_W-1:0] tile_column_phase, tile_row_phase;
  logic [PH_W-1:0] tile_column_phase_next, tile_row_phase_next;
  logic [OC_W-1:0] output_column, output_column_next;
  logic [OR_W-1:0] output_row, output_row_next;

  rbad_pkg::state_t state, state_next;

  // shared restoring divider, one quotient bit per cycle
  logic [AREA_W:0]    div_rem, rem_shift, rem_sub;
  logic [SUM_W-1:0]   div_quo, quo_next;
  logic [AREA_W-1:0]  div_den;
  logic [rbad_pkg::CNT_W-1:0] div_cnt;
  logic               div_ge, div_last, div_step;

  always_comb begin
    rem_shift = {div_rem[AREA_W-1:0], div_quo[SUM_W-1]};
    div_ge    = rem_shift >= {1'b0, div_den};
    rem_sub   = rem_shift - {1'b0, div_den};
    quo_next  = {div_quo[SUM_W-2:0], div_ge};
    div_last  = div_cnt == rbad_pkg::CNT_W'(SUM_W - 1);
    div_step  = (state == rbad_pkg::ST_DIV_W) || (state == rbad_pkg::ST_DIV_H) ||
                (state == rbad_pkg::ST_DIV_R) || (state == rbad_pkg::ST_DIV_G) ||
                (state == rbad_pkg::ST_DIV_B);
  end

  // per pixel working registers
  logic [23:0]       pix;
  logic [SZ_W-1:0]   ow_e, oh_e;
  logic [SUM_W-1:0]  sum_g, sum_b;
  logic [PIX_W-1:0]  mean_r, mean_g, mean_b;
  logic              tile_last;

  // column sum memory: blue, green, red from the top
  logic              ram_we, ram_re;
  logic [3*SUM_W-1:0] ram_wdata, ram_rdata;

  rbad_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_OUTPUT_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (output_column[OA_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (output_column[OA_W-1:0]),
    .rdata (ram_rdata)
  );

  // coverage and tile end tests on the effective sizes
  logic               row_cov, col_cov, tile_start, col_end, row_end, emit, frame_end;
  logic [SUM_W-1:0]   new_r, new_g, new_b;
  logic [PR_W-1:0]    ow_span, oh_span;

  always_comb begin
    ow_span    = PR_W'(ow_e) * PR_W'(bw);
    oh_span    = PR_W'(oh_e) * PR_W'(bh);
    row_cov    = (PR_W'(source_row) < oh_span) && (SZ_W'(output_row) < oh_e);
    col_cov    = row_cov && (PR_W'(source_column) < ow_span) &&
                 (SZ_W'(output_column) < ow_e);
    tile_start = (tile_row_phase == '0) && (tile_column_phase == '0);
    col_end    = BK_W'(tile_column_phase) >= bw - BK_W'(1);
    row_end    = BK_W'(tile_row_phase) >= bh - BK_W'(1);
    emit       = col_cov && col_end && row_end;
    frame_end  = (SZ_W'(output_row) >= oh_e - SZ_W'(1)) &&
                 (SZ_W'(output_column) >= ow_e - SZ_W'(1));
    new_r      = tile_start ? SUM_W'(pix[7:0]) :
                 ram_rdata[SUM_W-1:0] + SUM_W'(pix[7:0]);
    new_g      = tile_start ? SUM_W'(pix[15:8]) :
                 ram_rdata[2*SUM_W-1:SUM_W] + SUM_W'(pix[15:8]);
    new_b      = tile_start ? SUM_W'(pix[23:16]) :
                 ram_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(pix[23:16]);
    ram_wdata  = {new_b, new_g, new_r};
    ram_we     = (state == rbad_pkg::ST_UPDATE) && col_cov;
    ram_re     = (state == rbad_pkg::ST_IDLE) && s_tvalid;
  end

  // counter advance for one pixel; the end of a source row takes precedence
  always_comb begin
    source_column_next     = source_column;
    source_row_next        = source_row;
    tile_column_phase_next = tile_column_phase;
    tile_row_phase_next    = tile_row_phase;
    output_column_next     = output_column;
    output_row_next        = output_row;
    if (col_cov) begin
      if (col_end) begin
        tile_column_phase_next = '0;
        output_column_next     = output_column + OC_W'(1);
      end else begin
        tile_column_phase_next = tile_column_phase + PH_W'(1);
      end
    end
    // end of source row
    if (SZ_W'(source_column) >= sw - SZ_W'(1)) begin
      source_column_next     = '0;
      tile_column_phase_next = '0;
      output_column_next     = '0;
      if (row_cov) begin
        if (row_end) begin
          tile_row_phase_next = '0;
          output_row_next     = output_row + OR_W'(1);
        end else begin
          tile_row_phase_next = tile_row_phase + PH_W'(1);
        end
      end
      if (SZ_W'(source_row) >= sh - SZ_W'(1)) begin
        source_row_next     = '0;
        tile_row_phase_next = '0;
        output_row_next     = '0;
      end else begin
        source_row_next = source_row + SR_W'(1);
      end
    end else begin
      source_column_next = source_column + SC_W'(1);
    end
  end

  // saturated 8 bit mean from the quotient
  logic [PIX_W-1:0] mean_sat;
  assign mean_sat = (|quo_next[SUM_W-1:PIX_W]) ? '1 : quo_next[PIX_W-1:0];

  // next state and ready
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      rbad_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = rbad_pkg::ST_DIV_W;
        end
      end
      rbad_pkg::ST_DIV_W: if (div_last) state_next = rbad_pkg::ST_DIV_H;
      rbad_pkg::ST_DIV_H: if (div_last) state_next = rbad_pkg::ST_UPDATE;
      rbad_pkg::ST_UPDATE: begin
        state_next = emit ? rbad_pkg::ST_DIV_R : rbad_pkg::ST_IDLE;
      end
      rbad_pkg::ST_DIV_R: if (div_last) state_next = rbad_pkg::ST_DIV_G;
      rbad_pkg::ST_DIV_G: if (div_last) state_next = rbad_pkg::ST_DIV_B;
      rbad_pkg::ST_DIV_B: if (div_last) state_next = rbad_pkg::ST_OUT;
      rbad_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = rbad_pkg::ST_IDLE;
        end
      end
      default: state_next = rbad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      source_column     <= '0;
      source_row        <= '0;
      tile_column_phase <= '0;
      tile_row_phase    <= '0;
      output_column     <= '0;
      output_row        <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      // output register: load a finished tile, or free it after a transfer
      if ((state == rbad_pkg::ST_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      // last step of a division reloads below
      if (div_step && !div_last) begin
        div_rem <= div_ge ? rem_sub : rem_shift;
        div_quo <= quo_next;
        div_cnt <= div_cnt + rbad_pkg::CNT_W'(1);
      end
      case (state)
        rbad_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            pix     <= s_tdata;
            div_rem <= '0;
            div_quo <= SUM_W'(sw);
            div_den <= AREA_W'(bw);
            div_cnt <= '0;
          end
        end
        rbad_pkg::ST_DIV_W: begin
          if (div_last) begin
            ow_e    <= (SUM_W'(ow_c) > quo_next) ? quo_next[SZ_W-1:0] : ow_c;
            div_rem <= '0;
            div_quo <= SUM_W'(sh);
            div_den <= AREA_W'(bh);
            div_cnt <= '0;
          end
        end
        rbad_pkg::ST_DIV_H: begin
          if (div_last) begin
            oh_e <= (SUM_W'(oh_c) > quo_next) ? quo_next[SZ_W-1:0] : oh_c;
          end
        end
        rbad_pkg::ST_UPDATE: begin
          if (emit) begin
            sum_g     <= new_g;
            sum_b     <= new_b;
            tile_last <= frame_end;
            div_rem   <= '0;
            div_quo   <= new_r;
            div_den   <= AREA_W'(bw) * AREA_W'(bh);
            div_cnt   <= '0;
          end
          source_column     <= source_column_next;
          source_row        <= source_row_next;
          tile_column_phase <= tile_column_phase_next;
          tile_row_phase    <= tile_row_phase_next;
          output_column     <= output_column_next;
          output_row        <= output_row_next;
        end
        rbad_pkg::ST_DIV_R: begin
          if (div_last) begin
            mean_r  <= mean_sat;
            div_rem <= '0;
            div_quo <= sum_g;
            div_cnt <= '0;
          end
        end
        rbad_pkg::ST_DIV_G: begin
          if (div_last) begin
            mean_g  <= mean_sat;
            div_rem <= '0;
            div_quo <= sum_b;
            div_cnt <= '0;
          end
        end
        rbad_pkg::ST_DIV_B: begin
          if (div_last) begin
            mean_b <= mean_sat;
          end
        end
        rbad_pkg::ST_OUT: begin
          // output register frees up, hand the tile over
          if (!m_tvalid || m_tready) begin
            m_tdata <= {mean_b, mean_g, mean_r};
            m_tlast <= tile_last;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rbad_ram.sv
// ----------------------------------------------------------------------------
// rbad_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rbad_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rbad_checker.sv
// ----------------------------------------------------------------------------
// rbad_checker
// port level checks of the rgb block average downscaler
// ----------------------------------------------------------------------------
`include "rgb_block_average_downscaler_defines.svh"

module rbad_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result holds
  `RBAD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // one pixel at a time: no transfer in the cycle after one
  `RBAD_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // a new result is loaded only while the input side is closed
  `RBAD_ASSERT_NOW(a_load_closed, $rose(m_tvalid), !$past(s_tready))

endmodule

bind rgb_block_average_downscaler rbad_checker u_rbad_checker (.*);
